/* hw/rtl/fq_pkg.sv */
// Shared types, constants and helper functions for the float to uint8 quantizer.
// Used by every module under hw/rtl; depends on nothing else.
package fq_pkg;

	// Configuration register indexes.
	localparam logic CFG_SCALE      = 1'b0;
	localparam logic CFG_ZERO_POINT = 1'b1;

	// Register reset values and code limits.
	localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
	localparam logic [7:0]  CODE_MAX    = 8'd255;
	localparam logic [7:0]  CODE_MIN    = 8'd0;

	// The 26 quotient bits come two per divider stage.
	localparam int DIV_STAGES = 13;

	// Beat state while the mantissa quotient is being built.
	typedef struct packed {
		logic               fixed;       // code already known
		logic [7:0]         fixed_code;
		logic               zero;        // quotient is a signed zero
		logic               sign;
		logic signed [10:0] exp;         // exponent of sample minus scale
		logic [23:0]        mb;          // normalized scale mantissa
		logic [25:0]        rem;         // partial remainder
		logic [25:0]        quo;         // quotient bits so far
	} fq_work_t;

	// Beat state after the quotient is rounded to single precision.
	typedef struct packed {
		logic               fixed;
		logic [7:0]         fixed_code;
		logic               zero;
		logic               sign;
		logic signed [10:0] exp;         // unbiased exponent of the quotient
		logic [23:0]        sig;         // significand with hidden one
	} fq_rnd_t;

	// Leading zero count of a 24-bit mantissa with a nonzero value.
	function automatic logic [4:0] lzc24(input logic [23:0] m);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (m[i]) begin
				n = 5'(23 - i);
			end
		end
		return n;
	endfunction

endpackage

/* hw/rtl/float_to_uint8_affine_quantizer.sv */
// Top level of the float to uint8 affine quantizer: config registers and pipeline.
// Depends on fq_pkg, fq_unpack, fq_div_step, fq_round and fq_code.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    sample[31:0]
//   out      output     out_valid/out_stall  code[7:0]
//   cfg      input      cfg_we               cfg_index, cfg_data[31:0]
//
// One beat enters per cycle while in_stall is low.
// A beat passes the unpack stage, 13 divider stages of two quotient bits, rounding and output.
// Each stage holds its beat while the one after it is full and stalled.
// Reset clears the valid bits and loads scale 1.0 and zero point 0.
module float_to_uint8_affine_quantizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  code,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int N = fq_pkg::DIV_STAGES;

	logic [31:0] scale_q;
	logic [7:0]  zero_point_q;

	fq_pkg::fq_work_t unp_c, work_s1;
	fq_pkg::fq_work_t div_c [N];
	fq_pkg::fq_work_t div_s [N];
	fq_pkg::fq_rnd_t  rnd_c, rnd_s15;
	logic [7:0]       code_c, code_s16;

	logic       v_s1, v_s15, v_s16;
	logic [N-1:0] dv_s;
	logic       en1, en15, en16;
	logic [N-1:0] den;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q      <= fq_pkg::SCALE_RESET;
			zero_point_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fq_pkg::CFG_SCALE:      scale_q      <= cfg_data;
				fq_pkg::CFG_ZERO_POINT: zero_point_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stage enables: a stage loads when it is empty or its successor moves.
	assign en16 = !v_s16 || !out_stall;
	assign en15 = !v_s15 || en16;
	always_comb begin
		den[N-1] = !dv_s[N-1] || en15;
		for (int i = N - 2; i >= 0; i--) begin
			den[i] = !dv_s[i] || den[i+1];
		end
	end
	assign en1      = !v_s1 || den[0];
	assign in_stall = !en1;

	// Stage 1: unpack and normalize.
	fq_unpack u_unpack (
		.sample     (sample),
		.scale_bits (scale_q),
		.work       (unp_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			work_s1 <= unp_c;
		end
	end

	// Divider stages.
	for (genvar g = 0; g < N; g++) begin : g_div
		if (g == 0) begin : g_first
			fq_div_step u_step (.din(work_s1), .dout(div_c[g]));
		end else begin : g_next
			fq_div_step u_step (.din(div_s[g-1]), .dout(div_c[g]));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[g] <= 1'b0;
			end else if (den[g]) begin
				dv_s[g] <= (g == 0) ? v_s1 : dv_s[(g == 0) ? 0 : g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (den[g]) begin
				div_s[g] <= div_c[g];
			end
		end
	end

	// Single-precision rounding of the quotient.
	fq_round u_round (.work(div_s[N-1]), .rnd(rnd_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s15 <= 1'b0;
		end else if (en15) begin
			v_s15 <= dv_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en15) begin
			rnd_s15 <= rnd_c;
		end
	end

	// Integer rounding, zero point and clamp into the output register.
	fq_code u_code (.rnd(rnd_s15), .zero_point(zero_point_q), .code(code_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s16 <= 1'b0;
		end else if (en16) begin
			v_s16 <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (en16) begin
			code_s16 <= code_c;
		end
	end

	assign out_valid = v_s16;
	assign code      = code_s16;

`ifndef SYNTHESIS
	// Input backs up only when the whole pipe is full behind a stalled output.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && v_s1 && v_s15))
		else $error("input stalled while the pipeline has room");

	// An accepted beat lands in the first stage.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted beat lost at stage 1");

	// A delivered result is replaced by the rounding stage contents.
	a_out_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> (out_valid == $past(v_s15)))
		else $error("output valid does not follow the rounding stage");
`endif

endmodule

/* hw/rtl/fq_unpack.sv */
// Unpacks sample and scale, sorts out special operands and normalizes mantissas.
// Depends on fq_pkg.
module fq_unpack (
	input  logic [31:0]      sample,
	input  logic [31:0]      scale_bits,
	output fq_pkg::fq_work_t work
);

	logic        sa, sb;
	logic [7:0]  ea, eb;
	logic [22:0] fa, fb;
	logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
	logic [4:0]  lz_a, lz_b;
	logic [23:0] ma, mb;
	logic signed [10:0] xa, xb;

	// Field split and classification.
	assign sa = sample[31];
	assign ea = sample[30:23];
	assign fa = sample[22:0];
	assign sb = scale_bits[31];
	assign eb = scale_bits[30:23];
	assign fb = scale_bits[22:0];
	assign a_nan  = (ea == 8'hFF) && (fa != 23'd0);
	assign a_inf  = (ea == 8'hFF) && (fa == 23'd0);
	assign a_zero = (ea == 8'h00) && (fa == 23'd0);
	assign b_nan  = (eb == 8'hFF) && (fb != 23'd0);
	assign b_inf  = (eb == 8'hFF) && (fb == 23'd0);
	assign b_zero = (eb == 8'h00) && (fb == 23'd0);

	// Subnormal operands are shifted up so the hidden bit is set.
	assign lz_a = fq_pkg::lzc24({1'b0, fa});
	assign lz_b = fq_pkg::lzc24({1'b0, fb});
	assign ma = (ea == 8'h00) ? ({1'b0, fa} << lz_a) : {1'b1, fa};
	assign mb = (eb == 8'h00) ? ({1'b0, fb} << lz_b) : {1'b1, fb};
	assign xa = (ea == 8'h00) ? (-11'sd126 - $signed({6'b0, lz_a}))
	                          : ($signed({3'b0, ea}) - 11'sd127);
	assign xb = (eb == 8'h00) ? (-11'sd126 - $signed({6'b0, lz_b}))
	                          : ($signed({3'b0, eb}) - 11'sd127);

	// NaN, zero scale and infinite sample fix the code; the rest go to the divider.
	always_comb begin
		work            = '0;
		work.sign       = sa ^ sb;
		work.exp        = xa - xb;
		work.mb         = mb;
		work.rem        = {2'b0, ma};
		work.fixed_code = fq_pkg::CODE_MIN;
		if (a_nan || b_nan) begin
			work.fixed = 1'b1;
		end else if (b_zero) begin
			work.fixed = 1'b1;
			if (!a_zero && !(sa ^ sb)) begin
				work.fixed_code = fq_pkg::CODE_MAX;
			end
		end else if (a_inf) begin
			work.fixed = 1'b1;
			if (!b_inf && !(sa ^ sb)) begin
				work.fixed_code = fq_pkg::CODE_MAX;
			end
		end else if (b_inf || a_zero) begin
			work.zero = 1'b1;
		end
	end

endmodule

/* hw/rtl/fq_div_step.sv */
// One restoring divider step that yields two quotient bits of the mantissa ratio.
// Depends on fq_pkg.
module fq_div_step (
	input  fq_pkg::fq_work_t din,
	output fq_pkg::fq_work_t dout
);

	logic [25:0] mbx, r0n, r1, r1n, r2;
	logic        ge0, ge1;

	assign mbx = {2'b0, din.mb};

	// First bit: compare, subtract, shift.
	assign ge0 = din.rem >= mbx;
	assign r0n = ge0 ? (din.rem - mbx) : din.rem;
	assign r1  = {r0n[24:0], 1'b0};

	// Second bit.
	assign ge1 = r1 >= mbx;
	assign r1n = ge1 ? (r1 - mbx) : r1;
	assign r2  = {r1n[24:0], 1'b0};

	always_comb begin
		dout     = din;
		dout.rem = r2;
		dout.quo = {din.quo[23:0], ge0, ge1};
	end

endmodule

/* hw/rtl/fq_round.sv */
// Rounds the mantissa quotient to single precision, ties to even.
// Depends on fq_pkg.
module fq_round (
	input  fq_pkg::fq_work_t work,
	output fq_pkg::fq_rnd_t  rnd
);

	logic [23:0] sig;
	logic        guard, sticky, up;
	logic [24:0] sum;
	logic signed [10:0] e;

	// Pick the 24 leading bits depending on whether the ratio is below one.
	always_comb begin
		if (work.quo[25]) begin
			sig    = work.quo[25:2];
			guard  = work.quo[1];
			sticky = work.quo[0] | (work.rem != 26'd0);
			e      = work.exp;
		end else begin
			sig    = work.quo[24:1];
			guard  = work.quo[0];
			sticky = work.rem != 26'd0;
			e      = work.exp - 11'sd1;
		end
	end

	assign up  = guard & (sticky | sig[0]);
	assign sum = {1'b0, sig} + {24'd0, up};

	// A carry out of the significand bumps the exponent.
	always_comb begin
		rnd.fixed      = work.fixed;
		rnd.fixed_code = work.fixed_code;
		rnd.zero       = work.zero;
		rnd.sign       = work.sign;
		if (sum[24]) begin
			rnd.sig = 24'h80_0000;
			rnd.exp = e + 11'sd1;
		end else begin
			rnd.sig = sum[23:0];
			rnd.exp = e;
		end
	end

endmodule

/* hw/rtl/fq_code.sv */
// Rounds the single-precision quotient to an integer, adds the zero point, clamps.
// Depends on fq_pkg.
module fq_code (
	input  fq_pkg::fq_rnd_t rnd,
	input  logic [7:0]      zero_point,
	output logic [7:0]      code
);

	logic [3:0]  sh;
	logic [33:0] x;
	logic [9:0]  ipart;
	logic        half, rest, up;
	logic [10:0] mag;
	logic signed [11:0] sval, total;

	// Line the binary point up between bit 24 and bit 23.
	assign sh    = 4'(rnd.exp + 11'sd1);
	assign x     = {10'd0, rnd.sig} << sh;
	assign ipart = x[33:24];
	assign half  = x[23];
	assign rest  = |x[22:0];
	assign up    = half & (rest | ipart[0]);

	always_comb begin
		if (rnd.zero || (rnd.exp < -11'sd1)) begin
			mag = 11'd0;
		end else begin
			mag = {1'b0, ipart} + {10'd0, up};
		end
	end

	assign sval  = rnd.sign ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	assign total = sval + $signed({4'd0, zero_point});

	// Saturation and clamp to the code range.
	always_comb begin
		if (rnd.fixed) begin
			code = rnd.fixed_code;
		end else if (!rnd.zero && (rnd.exp > 11'sd8)) begin
			code = rnd.sign ? fq_pkg::CODE_MIN : fq_pkg::CODE_MAX;
		end else if (total < 12'sd0) begin
			code = fq_pkg::CODE_MIN;
		end else if (total > 12'sd255) begin
			code = fq_pkg::CODE_MAX;
		end else begin
			code = total[7:0];
		end
	end

endmodule
